>>> design/falru_pkg.sv
// ----------------------------------------------------------------------------
// falru_pkg
// Shared widths, outcome codes, register indexes, command codes and control
// bundles of the fully associative LRU tag store.
// ----------------------------------------------------------------------------
package falru_pkg;

    // Fixed field widths
    localparam int LINE_W     = 32;
    localparam int ADDR_W     = 32;
    localparam int CNT_W      = 32;
    localparam int LAT_W      = 48;
    localparam int COST_W     = 11;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;

    // Access outcome codes
    localparam logic [1:0] OUT_HIT      = 2'd0;
    localparam logic [1:0] OUT_COLD     = 2'd1;
    localparam logic [1:0] OUT_CAPACITY = 2'd2;
    localparam logic [1:0] OUT_CLEARED  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SHIFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINES_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_LATENCY  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_PENALTY = 2'd3;

    // Command codes
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Control broadcast to every cell of the recency chain
    typedef struct packed {
        logic cmp;    // capture tag match
        logic upd;    // commit the shift of this transaction
        logic clear;  // empty the cell
    } t_cell_ctl;

    // Event strobe for the statistics block
    typedef struct packed {
        logic upd;
        logic clear;
        logic hit;
        logic cold;
        logic capacity;
    } t_stat_evt;

endpackage

>>> design/falru_if.sv
// ----------------------------------------------------------------------------
// falru_req_if / falru_rsp_if
// Valid/ready channels carrying access requests and access results.
// ----------------------------------------------------------------------------
interface falru_req_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [falru_pkg::ADDR_W-1:0]  byte_address;

    modport source (output valid, command, byte_address, input ready);
    modport sink   (input valid, command, byte_address, output ready);
endinterface

interface falru_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [1:0]                    outcome;
    logic [falru_pkg::LINE_W-1:0]  line_number;
    logic                          evicted_valid;
    logic [falru_pkg::LINE_W-1:0]  evicted_line;
    logic [falru_pkg::CNT_W-1:0]   access_count;
    logic [falru_pkg::CNT_W-1:0]   hit_count;
    logic [falru_pkg::CNT_W-1:0]   miss_count;
    logic [falru_pkg::CNT_W-1:0]   cold_miss_count;
    logic [falru_pkg::CNT_W-1:0]   capacity_miss_count;
    logic [falru_pkg::LAT_W-1:0]   latency_total;

    modport source (output valid, hit, outcome, line_number, evicted_valid, evicted_line,
                    access_count, hit_count, miss_count, cold_miss_count,
                    capacity_miss_count, latency_total, input ready);
    modport sink   (input valid, hit, outcome, line_number, evicted_valid, evicted_line,
                    access_count, hit_count, miss_count, cold_miss_count,
                    capacity_miss_count, latency_total, output ready);
endinterface

>>> design/falru_cell.sv
// ----------------------------------------------------------------------------
// falru_cell
// One position of the recency chain: holds a tag and its valid bit, flags a
// match against the looked-up line and takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module falru_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  falru_pkg::t_cell_ctl          i_ctl,
    input  logic [falru_pkg::LINE_W-1:0]  i_line,
    input  logic                          i_take,
    input  logic [falru_pkg::LINE_W-1:0]  i_prev_tag,
    input  logic                          i_prev_valid,
    output logic [falru_pkg::LINE_W-1:0]  o_tag,
    output logic                          o_valid,
    output logic                          o_match
);

    logic [falru_pkg::LINE_W-1:0] r_tag;
    logic                         r_valid;
    logic                         r_match;
    logic                         w_shift;

    assign w_shift = i_ctl.upd & ~i_ctl.clear & i_take;

    // Capture match and move the valid bit along the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_match <= r_valid & (r_tag == i_line);
            end
            if (i_ctl.upd && i_ctl.clear) begin
                r_valid <= 1'b0;
            end else if (w_shift) begin
                r_valid <= i_prev_valid;
            end
        end
    end

    // Take the neighbor's tag on a shift
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_tag <= i_prev_tag;
        end
    end

    assign o_tag   = r_tag;
    assign o_valid = r_valid;
    assign o_match = r_match;

endmodule

>>> design/falru_stats.sv
// ----------------------------------------------------------------------------
// falru_stats
// Saturating event counters and latency accumulator, updated once per
// committed transaction and zeroed by a clear command.
// ----------------------------------------------------------------------------
module falru_stats (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  falru_pkg::t_stat_evt          i_evt,
    input  logic [7:0]                    i_hit_latency,
    input  logic [9:0]                    i_miss_penalty,
    output logic [falru_pkg::CNT_W-1:0]   o_access_count,
    output logic [falru_pkg::CNT_W-1:0]   o_hit_count,
    output logic [falru_pkg::CNT_W-1:0]   o_miss_count,
    output logic [falru_pkg::CNT_W-1:0]   o_cold_count,
    output logic [falru_pkg::CNT_W-1:0]   o_capacity_count,
    output logic [falru_pkg::LAT_W-1:0]   o_latency_total
);

    localparam logic [falru_pkg::CNT_W-1:0] CNT_MAX = '1;
    localparam logic [falru_pkg::LAT_W-1:0] LAT_MAX = '1;

    logic [falru_pkg::CNT_W-1:0]  r_access, r_hit, r_miss, r_cold, r_capacity;
    logic [falru_pkg::LAT_W-1:0]  r_latency;
    logic [falru_pkg::COST_W-1:0] w_cost;
    logic [falru_pkg::LAT_W:0]    w_lat_sum;
    logic                         w_miss;
    logic                         w_access;

    assign w_access = i_evt.upd & ~i_evt.clear;
    assign w_miss   = i_evt.cold | i_evt.capacity;

    // Charge latency, plus penalty on a miss
    assign w_cost    = falru_pkg::COST_W'(i_hit_latency)
                     + (w_miss ? falru_pkg::COST_W'(i_miss_penalty) : '0);
    assign w_lat_sum = {1'b0, r_latency} + (falru_pkg::LAT_W + 1)'(w_cost);

    // Advance counters, holding each at its ceiling
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_access   <= '0;
            r_hit      <= '0;
            r_miss     <= '0;
            r_cold     <= '0;
            r_capacity <= '0;
            r_latency  <= '0;
        end else if (i_evt.upd && i_evt.clear) begin
            r_access   <= '0;
            r_hit      <= '0;
            r_miss     <= '0;
            r_cold     <= '0;
            r_capacity <= '0;
            r_latency  <= '0;
        end else if (w_access) begin
            if (r_access != CNT_MAX) begin
                r_access <= r_access + 1'b1;
            end
            if (i_evt.hit && r_hit != CNT_MAX) begin
                r_hit <= r_hit + 1'b1;
            end
            if (w_miss && r_miss != CNT_MAX) begin
                r_miss <= r_miss + 1'b1;
            end
            if (i_evt.cold && r_cold != CNT_MAX) begin
                r_cold <= r_cold + 1'b1;
            end
            if (i_evt.capacity && r_capacity != CNT_MAX) begin
                r_capacity <= r_capacity + 1'b1;
            end
            r_latency <= w_lat_sum[falru_pkg::LAT_W] ? LAT_MAX
                                                    : w_lat_sum[falru_pkg::LAT_W-1:0];
        end
    end

    assign o_access_count   = r_access;
    assign o_hit_count      = r_hit;
    assign o_miss_count     = r_miss;
    assign o_cold_count     = r_cold;
    assign o_capacity_count = r_capacity;
    assign o_latency_total  = r_latency;

endmodule

>>> design/fully_associative_lru_tag_store.sv
// ----------------------------------------------------------------------------
// fully_associative_lru_tag_store
// Fully associative tag store with least-recently-used replacement, built as
// a chain of cells ordered by recency, with access statistics.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one transaction: command (access or clear) and a byte
//   address. o_rsp returns one result per transaction: hit flag, outcome,
//   line number, evicted line and the statistics after that transaction.
//   The chain keeps valid lines packed from cell 0 (most recent) onward; a
//   hit or miss shifts the leading cells one place and writes the line into
//   cell 0, and a capacity miss drops the last valid cell.
//   A request passes the compare, encode and shift states, and its result is
//   then loaded into the output register. One request is in flight at a time:
//   a new one is taken only after the last has left the shift state.
//   The output register decouples the sides: a request is taken while a
//   result still waits; if the receiver stalls, the shift state holds until
//   the waiting result is taken.
//   Reset empties the store, zeroes statistics and loads register defaults.
//   Write registers through i_cfg_* only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module fully_associative_lru_tag_store #(
    parameter int NUM_LINES = 64,
    parameter int ADDR_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    falru_req_if.sink                            i_req,
    falru_rsp_if.source                          o_rsp,
    input  logic                                 i_cfg_we,
    input  logic [falru_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [falru_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int IDX_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int FILL_W   = $clog2(NUM_LINES + 1);
    localparam int CAP_W    = (FILL_W > 7) ? FILL_W : 7;
    localparam int MASK_W   = (ADDR_BITS < falru_pkg::ADDR_W) ? ADDR_BITS : falru_pkg::ADDR_W;
    localparam logic [falru_pkg::ADDR_W-1:0] ADDR_MASK =
        {falru_pkg::ADDR_W{1'b1}} >> (falru_pkg::ADDR_W - MASK_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_ENC  = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    // Configuration registers
    logic [3:0] r_line_shift;
    logic [6:0] r_lines_in_use;
    logic [7:0] r_hit_latency;
    logic [9:0] r_miss_penalty;

    // Control and transaction registers
    logic [1:0]                     r_state, n_state;
    logic                           r_cmd;
    logic [falru_pkg::LINE_W-1:0]   r_line;
    logic                           r_hit;
    logic                           r_cold;
    logic [IDX_W-1:0]               r_take_idx;
    logic [falru_pkg::LINE_W-1:0]   r_evict_line;
    logic [FILL_W-1:0]              r_filled;

    // Output register
    logic                           r_out_valid;
    logic                           r_out_hit;
    logic [1:0]                     r_out_outcome;
    logic [falru_pkg::LINE_W-1:0]   r_out_line;
    logic                           r_out_ev_valid;
    logic [falru_pkg::LINE_W-1:0]   r_out_ev_line;

    // Chain signals
    logic [NUM_LINES-1:0]           w_valid;
    logic [NUM_LINES-1:0]           w_match;
    logic [falru_pkg::LINE_W-1:0]   w_tag [NUM_LINES];
    falru_pkg::t_cell_ctl           w_cell_ctl;
    falru_pkg::t_stat_evt           w_stat_evt;

    logic                           w_accept;
    logic                           w_upd;
    logic [falru_pkg::LINE_W-1:0]   w_line;
    logic                           w_hit_any;
    logic [IDX_W-1:0]               w_hit_idx;
    logic [falru_pkg::LINE_W-1:0]   w_evict_line;
    logic [CAP_W-1:0]               w_cap_raw;
    logic [CAP_W-1:0]               w_cap;
    logic                           w_cold;
    logic [IDX_W-1:0]               w_fill_last;

    assign w_accept = i_req.valid & i_req.ready;
    assign w_upd    = (r_state == ST_UPD) && (!r_out_valid || o_rsp.ready);
    assign w_line   = (i_req.byte_address & ADDR_MASK) >> r_line_shift;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_shift   <= 4'd6;
            r_lines_in_use <= 7'd64;
            r_hit_latency  <= 8'd4;
            r_miss_penalty <= 10'd12;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                falru_pkg::CFG_LINE_SHIFT:   r_line_shift   <= i_cfg_data[3:0];
                falru_pkg::CFG_LINES_IN_USE: r_lines_in_use <= i_cfg_data[6:0];
                falru_pkg::CFG_HIT_LATENCY:  r_hit_latency  <= i_cfg_data[7:0];
                falru_pkg::CFG_MISS_PENALTY: r_miss_penalty <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Sequence one transaction: compare, encode, shift
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_CMP;
            ST_CMP:  n_state = ST_ENC;
            ST_ENC:  n_state = ST_UPD;
            ST_UPD:  if (w_upd) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_req.ready = (r_state == ST_IDLE);

    // Latch the request and form the line number
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_req.command;
            r_line <= w_line;
        end
    end

    // Recency chain
    assign w_cell_ctl.cmp   = (r_state == ST_CMP);
    assign w_cell_ctl.upd   = w_upd;
    assign w_cell_ctl.clear = (r_cmd == falru_pkg::CMD_CLEAR);

    for (genvar g = 0; g < NUM_LINES; g++) begin : g_cell
        logic [falru_pkg::LINE_W-1:0] w_prev_tag;
        logic                         w_prev_valid;
        logic                         w_take;

        if (g == 0) begin : g_head
            assign w_prev_tag   = r_line;
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_tag   = w_tag[g-1];
            assign w_prev_valid = w_valid[g-1];
        end

        assign w_take = (IDX_W'(g) <= r_take_idx);

        falru_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_cell_ctl),
            .i_line       (r_line),
            .i_take       (w_take),
            .i_prev_tag   (w_prev_tag),
            .i_prev_valid (w_prev_valid),
            .o_tag        (w_tag[g]),
            .o_valid      (w_valid[g]),
            .o_match      (w_match[g])
        );
    end

    // Encode hit position and pick the least recent valid line
    assign w_fill_last = IDX_W'(r_filled - 1'b1);

    always_comb begin
        w_hit_idx    = '0;
        w_evict_line = '0;
        for (int i = 0; i < NUM_LINES; i++) begin
            if (w_match[i]) begin
                w_hit_idx = w_hit_idx | IDX_W'(i);
            end
            if (IDX_W'(i) == w_fill_last) begin
                w_evict_line = w_evict_line | w_tag[i];
            end
        end
    end

    assign w_hit_any = |w_match;

    // Clamp capacity into one..NUM_LINES
    assign w_cap_raw = CAP_W'(r_lines_in_use);
    always_comb begin
        if (w_cap_raw == '0) begin
            w_cap = CAP_W'(1);
        end else if (w_cap_raw > CAP_W'(NUM_LINES)) begin
            w_cap = CAP_W'(NUM_LINES);
        end else begin
            w_cap = w_cap_raw;
        end
    end
    assign w_cold = (CAP_W'(r_filled) < w_cap);

    // Register lookup result and shift extent
    always_ff @(posedge i_clk) begin
        if (r_state == ST_ENC) begin
            r_hit        <= (r_cmd == falru_pkg::CMD_ACCESS) & w_hit_any;
            r_cold       <= w_cold;
            r_evict_line <= w_evict_line;
            if (w_hit_any) begin
                r_take_idx <= w_hit_idx;
            end else if (w_cold) begin
                r_take_idx <= IDX_W'(NUM_LINES - 1);
            end else begin
                r_take_idx <= w_fill_last;
            end
        end
    end

    // Track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
        end else if (w_upd) begin
            if (r_cmd == falru_pkg::CMD_CLEAR) begin
                r_filled <= '0;
            end else if (!r_hit && r_cold) begin
                r_filled <= r_filled + 1'b1;
            end
        end
    end

    // Statistics
    assign w_stat_evt.upd      = w_upd;
    assign w_stat_evt.clear    = (r_cmd == falru_pkg::CMD_CLEAR);
    assign w_stat_evt.hit      = r_hit;
    assign w_stat_evt.cold     = (r_cmd == falru_pkg::CMD_ACCESS) & ~r_hit & r_cold;
    assign w_stat_evt.capacity = (r_cmd == falru_pkg::CMD_ACCESS) & ~r_hit & ~r_cold;

    falru_stats u_stats (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_evt            (w_stat_evt),
        .i_hit_latency    (r_hit_latency),
        .i_miss_penalty   (r_miss_penalty),
        .o_access_count   (o_rsp.access_count),
        .o_hit_count      (o_rsp.hit_count),
        .o_miss_count     (o_rsp.miss_count),
        .o_cold_count     (o_rsp.cold_miss_count),
        .o_capacity_count (o_rsp.capacity_miss_count),
        .o_latency_total  (o_rsp.latency_total)
    );

    // Load the result; drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_upd) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_out_hit      <= r_hit;
            r_out_ev_valid <= 1'b0;
            r_out_ev_line  <= '0;
            if (r_cmd == falru_pkg::CMD_CLEAR) begin
                r_out_outcome <= falru_pkg::OUT_CLEARED;
                r_out_line    <= '0;
            end else begin
                r_out_line <= r_line;
                if (r_hit) begin
                    r_out_outcome <= falru_pkg::OUT_HIT;
                end else if (r_cold) begin
                    r_out_outcome <= falru_pkg::OUT_COLD;
                end else begin
                    r_out_outcome  <= falru_pkg::OUT_CAPACITY;
                    r_out_ev_valid <= 1'b1;
                    r_out_ev_line  <= r_evict_line;
                end
            end
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_out_hit;
    assign o_rsp.outcome       = r_out_outcome;
    assign o_rsp.line_number   = r_out_line;
    assign o_rsp.evicted_valid = r_out_ev_valid;
    assign o_rsp.evicted_line  = r_out_ev_line;

    // Checks
    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("more than one cell matched the line");

    a_packed_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_filled))
        else $error("valid cells do not agree with fill count");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= FILL_W'(NUM_LINES))
        else $error("fill count above store size");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_req.ready)
        else $error("request taken while another is in flight");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_hit) |->
            (r_out_outcome == falru_pkg::OUT_HIT) && !r_out_ev_valid)
        else $error("hit result reports an eviction");

endmodule
